>>> design/tobm_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// tobm_pkg
// Shared constants, types and register codes of the threshold outer boundary
// marker.
// -----------------------------------------------------------------------------
package tobm_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int IWIDTH_W   = 11;
  localparam int LW         = (COL_W + 1 > IWIDTH_W) ? COL_W + 1 : IWIDTH_W;
  localparam int CH_W       = 8;
  localparam int SUM_W      = 10;
  localparam int THRESH_W   = 10;
  localparam int COLUMN_W   = 10;
  localparam int ROWS_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [THRESH_W-1:0] THRESHOLD_RESET = THRESH_W'(300);
  localparam logic [IWIDTH_W-1:0] WIDTH_RESET     = IWIDTH_W'(650);
  localparam logic [ROWS_W-1:0]   ROWS_FULL       = ROWS_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SUM_THRESHOLD = CFG_IDX_W'(0),
    REG_IMAGE_WIDTH   = CFG_IDX_W'(1)
  } cfg_reg_t;

  // One line store entry: foreground bit of the row above and of the row
  // two above at the same column.
  typedef struct packed {
    logic fg;
    logic up;
  } line_bits_t;

  localparam int LINE_BITS_W = $bits(line_bits_t);

  // Neighborhood of the pixel one row above the current position.
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             first_col;
    logic             last_col;
    logic             rows_valid;
    logic             top;
    logic             center;
    logic             upper;
    logic             left;
    logic             right;
  } win_t;

endpackage
`default_nettype wire

>>> design/tobm_pix_if.sv
`default_nettype none
// -----------------------------------------------------------------------------
// tobm_pix_if
// Pixel input channel with valid/ready handshake.
// -----------------------------------------------------------------------------
interface tobm_pix_if;
  import tobm_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;
  logic            flush;

  modport source (output valid, output red, output green, output blue, output flush,
                  input ready);
  modport sink (input valid, input red, input green, input blue, input flush,
                output ready);
endinterface
`default_nettype wire

>>> design/tobm_res_if.sv
`default_nettype none
// -----------------------------------------------------------------------------
// tobm_res_if
// Contour result channel with valid/ready handshake.
// -----------------------------------------------------------------------------
interface tobm_res_if;
  import tobm_pkg::*;

  logic                valid;
  logic                ready;
  logic                edge_res;
  logic [COLUMN_W-1:0] column;
  logic                frame_end;

  modport source (output valid, output edge_res, output column, output frame_end,
                  input ready);
  modport sink (input valid, input edge_res, input column, input frame_end,
                output ready);
endinterface
`default_nettype wire

>>> design/tobm_cfg_if.sv
`default_nettype none
// -----------------------------------------------------------------------------
// tobm_cfg_if
// Configuration register write channel with valid/ready handshake.
// -----------------------------------------------------------------------------
interface tobm_cfg_if;
  import tobm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> design/tobm_ram.sv
`default_nettype none
// -----------------------------------------------------------------------------
// tobm_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered. A read at the address written in the same cycle returns
// the old contents.
// -----------------------------------------------------------------------------
module tobm_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> design/tobm_cfg_regs.sv
`default_nettype none
// -----------------------------------------------------------------------------
// tobm_cfg_regs
// Threshold and image width registers behind the configuration write channel.
// -----------------------------------------------------------------------------
module tobm_cfg_regs (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  tobm_cfg_if.sink                     cfg_wr,
  output logic [tobm_pkg::THRESH_W-1:0] sum_threshold,
  output logic [tobm_pkg::IWIDTH_W-1:0] image_width
);
  import tobm_pkg::*;

  logic [THRESH_W-1:0] thr_r;
  logic [THRESH_W-1:0] thr_nxt;
  logic [IWIDTH_W-1:0] width_r;
  logic [IWIDTH_W-1:0] width_nxt;

  assign cfg_wr.ready = 1'b1;

  always_comb begin
    thr_nxt   = thr_r;
    width_nxt = width_r;
    if (cfg_wr.valid) begin
      case (cfg_reg_t'(cfg_wr.index))
        REG_SUM_THRESHOLD: thr_nxt   = cfg_wr.data[THRESH_W-1:0];
        REG_IMAGE_WIDTH:   width_nxt = cfg_wr.data[IWIDTH_W-1:0];
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= THRESHOLD_RESET;
      width_r <= WIDTH_RESET;
    end else begin
      thr_r   <= thr_nxt;
      width_r <= width_nxt;
    end
  end

  assign sum_threshold = thr_r;
  assign image_width   = width_r;

endmodule
`default_nettype wire

>>> design/tobm_window.sv
`default_nettype none
// -----------------------------------------------------------------------------
// tobm_window
// Line store and column sequencer. One RAM holds, per column, the foreground
// bits of the two previous rows. The entry to the right is read one item
// ahead, a write that hits the pending read address is forwarded, and column
// zero is mirrored in a register so that a row wrap needs no second read.
// -----------------------------------------------------------------------------
module tobm_window (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [tobm_pkg::IWIDTH_W-1:0] image_width,
  input  wire logic                     step,
  input  wire logic                     flush,
  input  wire logic                     cur,
  output tobm_pkg::win_t                win
);
  import tobm_pkg::*;

  logic [COL_W-1:0]  cnt_r;
  logic [COL_W-1:0]  cnt_nxt;
  logic [ROWS_W-1:0] rows_r;
  logic [ROWS_W-1:0] rows_nxt;
  logic [COL_W-1:0]  rd_addr_r;
  logic [COL_W-1:0]  rd_addr;
  logic              fwd_r;
  line_bits_t        fwd_bits_r;
  line_bits_t        e0_r;
  line_bits_t        cen_r;
  logic              left_r;
  line_bits_t        rd_data;
  line_bits_t        center;
  line_bits_t        right;
  line_bits_t        wr_bits;
  logic [LW-1:0]     w_ext;
  logic [LW-1:0]     w_act;
  logic [LW-1:0]     col_ext;
  logic              last;
  logic              first;

  always_comb begin
    w_ext = LW'(image_width);
    if (w_ext == '0) begin
      w_act = LW'(1);
    end else if (w_ext > LW'(MAX_WIDTH)) begin
      w_act = LW'(MAX_WIDTH);
    end else begin
      w_act = w_ext;
    end
    col_ext = LW'(cnt_r);
    last    = (col_ext + LW'(1)) >= w_act;
    first   = (cnt_r == '0);
  end

  assign center     = first ? e0_r : cen_r;
  assign right      = fwd_r ? fwd_bits_r : rd_data;
  assign wr_bits.fg = cur;
  assign wr_bits.up = center.fg;

  always_comb begin
    cnt_nxt  = cnt_r;
    rows_nxt = rows_r;
    rd_addr  = rd_addr_r;
    if (step) begin
      if (last) begin
        cnt_nxt = '0;
        rd_addr = COL_W'(1);
        if (flush) begin
          rows_nxt = '0;
        end else if (rows_r < ROWS_FULL) begin
          rows_nxt = rows_r + ROWS_W'(1);
        end
      end else begin
        cnt_nxt = cnt_r + COL_W'(1);
        rd_addr = cnt_r + COL_W'(2);
      end
    end
  end

  tobm_ram #(
    .WIDTH (LINE_BITS_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (step),
    .waddr (cnt_r),
    .wdata (wr_bits),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      rows_r    <= '0;
      rd_addr_r <= COL_W'(1);
      fwd_r     <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      rows_r    <= rows_nxt;
      rd_addr_r <= rd_addr;
      fwd_r     <= step && (cnt_r == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    fwd_bits_r <= wr_bits;
    if (step) begin
      left_r <= center.fg;
      if (!last) begin
        cen_r <= right;
      end
      if (first) begin
        e0_r <= wr_bits;
      end
    end
  end

  always_comb begin
    win.col        = cnt_r;
    win.first_col  = first;
    win.last_col   = last;
    win.rows_valid = (rows_r != '0);
    win.top        = (rows_r == ROWS_W'(1));
    win.center     = center.fg;
    win.upper      = center.up;
    win.left       = left_r;
    win.right      = right.fg;
  end

  a_rd_ahead: assert property (@(posedge clk) disable iff (!rst_n)
    rd_addr_r == cnt_r + COL_W'(1))
    else $error("read address is not one column ahead");

  a_fwd_src: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> $past(step))
    else $error("forwarding without a preceding write");

  a_rows_sat: assert property (@(posedge clk) disable iff (!rst_n)
    rows_r <= ROWS_FULL)
    else $error("row count beyond two");

endmodule
`default_nettype wire

>>> design/threshold_outer_boundary_marker.sv
`default_nettype none
// -----------------------------------------------------------------------------
// threshold_outer_boundary_marker
// Binary threshold boundary extraction on a raster RGB pixel stream.
// -----------------------------------------------------------------------------
// The block takes one pixel per clock unless a result stalls, and gives at
// most one result per pixel, describing the pixel one row above; the first
// row of a frame gives no results and a row of flush items after the last
// row pushes out the final row. Each pixel passes through a single stage:
// the R+G+B compare, the neighbor test and the output register. The rate is
// set by the line store, one RAM with one read and one write per cycle,
// whose right-hand neighbor is read one pixel ahead. The store needs no
// clearing pass after reset. A stalled result holds the input back only
// while the output register is full and not taken.
module threshold_outer_boundary_marker (
  input  wire logic clk,
  input  wire logic rst_n,
  tobm_pix_if.sink  in_pix,
  tobm_res_if.source out_res,
  tobm_cfg_if.sink  cfg_wr
);
  import tobm_pkg::*;

  logic [THRESH_W-1:0] sum_threshold;
  logic [IWIDTH_W-1:0] image_width;
  win_t                win;
  logic [SUM_W-1:0]    sum;
  logic                cur;
  logic                in_acc;
  logic                step;
  logic                produce;
  logic                edge_nxt;
  logic [LW-1:0]       col_ext;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic                out_edge_r;
  logic [COLUMN_W-1:0] out_column_r;
  logic                out_frame_end_r;

  tobm_cfg_regs u_cfg_regs (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr        (cfg_wr),
    .sum_threshold (sum_threshold),
    .image_width   (image_width)
  );

  assign in_pix.ready = !out_valid_r || out_res.ready;
  assign in_acc       = in_pix.valid && in_pix.ready;
  assign step         = in_acc && !(in_pix.flush && !win.rows_valid);
  assign produce      = step && win.rows_valid;

  assign sum = SUM_W'(in_pix.red) + SUM_W'(in_pix.green) + SUM_W'(in_pix.blue);
  assign cur = !in_pix.flush && (sum >= sum_threshold);

  tobm_window u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .image_width (image_width),
    .step        (step),
    .flush       (in_pix.flush),
    .cur         (cur),
    .win         (win)
  );

  always_comb begin
    if (win.center) begin
      edge_nxt = win.top || in_pix.flush || win.first_col || win.last_col;
    end else begin
      edge_nxt = (!win.top && win.upper) || cur ||
                 (!win.first_col && win.left) || (!win.last_col && win.right);
    end
    col_ext = LW'(win.col);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (produce) begin
      out_valid_nxt = 1'b1;
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      out_edge_r      <= edge_nxt;
      out_column_r    <= COLUMN_W'(col_ext);
      out_frame_end_r <= in_pix.flush && win.last_col;
    end
  end

  assign out_res.valid     = out_valid_r;
  assign out_res.edge_res  = out_edge_r;
  assign out_res.column    = out_column_r;
  assign out_res.frame_end = out_frame_end_r;

  a_produce_shows: assert property (@(posedge clk) disable iff (!rst_n)
    produce |=> out_valid_r)
    else $error("result item lost after the neighbor test");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res.ready) |-> !in_pix.ready)
    else $error("input item taken while the result register is stalled");

  a_frame_end_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (produce && in_pix.flush && win.last_col) |=> !win.rows_valid)
    else $error("frame end did not return the row count to start");

endmodule
`default_nettype wire

>>> sim/tb_threshold_outer_boundary_marker.sv
`default_nettype none
// -----------------------------------------------------------------------------
// tb_threshold_outer_boundary_marker
// Self-checking bench for the threshold outer boundary marker. Pixel rows and
// flush rows are streamed in with random gaps on the input and random stalls
// on the result side. A line-store model inside the bench predicts every
// contour result at input acceptance. Results are checked in order, field by
// field.
// -----------------------------------------------------------------------------
module tb_threshold_outer_boundary_marker;
  import tobm_pkg::*;

  localparam int SETTLE       = 8;
  localparam int RANDOM_ITEMS = 220;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            flush;
  } pixel_t;

  typedef struct packed {
    logic                edge_res;
    logic [COLUMN_W-1:0] column;
    logic                frame_end;
  } contour_t;

  logic clk;
  logic rst_n;

  tobm_pix_if pix_bus ();
  tobm_res_if res_bus ();
  tobm_cfg_if cfg_bus ();

  threshold_outer_boundary_marker uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_pix (pix_bus),
    .out_res(res_bus),
    .cfg_wr (cfg_bus)
  );

  pixel_t   pending_pixels[$];
  contour_t awaited_contours[$];
  int       mismatches = 0;
  int       pixels_taken = 0;
  int       fed = 0;
  bit       pix_busy = 1'b0;

  // Bench copy of the block's registers, line stores and counters.
  logic [THRESH_W-1:0] thr_m = THRESHOLD_RESET;
  logic [IWIDTH_W-1:0] wid_m = WIDTH_RESET;
  bit                  row_above_m[MAX_WIDTH];
  bit                  row_two_above_m[MAX_WIDTH];
  int unsigned         col_m = 0;
  int unsigned         rows_m = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic bit steady_window();
    return pixels_taken >= 300 && pixels_taken < 900;
  endfunction

  function automatic void mark_pixel(pixel_t px);
    int unsigned w;
    int unsigned c;
    int unsigned sum;
    bit          last;
    bit          cur;
    bit          top;
    bit          hit;
    contour_t    res;
    w = (wid_m == 0) ? 1 : ((wid_m > MAX_WIDTH) ? MAX_WIDTH : wid_m);
    c = (col_m >= MAX_WIDTH) ? 0 : col_m;
    if (px.flush && rows_m == 0) return;
    last = (c + 1 >= w);
    sum  = px.red + px.green + px.blue;
    cur  = !px.flush && (sum >= thr_m);
    if (rows_m >= 1) begin
      top = (rows_m == 1);
      if (row_above_m[c]) begin
        hit = top || px.flush || c == 0 || last;
      end else begin
        hit = cur || (!top && row_two_above_m[c]);
        if (c > 0) begin
          if (row_two_above_m[c - 1]) hit = 1'b1;
        end
        if (!last && c + 1 < MAX_WIDTH) begin
          if (row_above_m[c + 1]) hit = 1'b1;
        end
      end
      res.edge_res  = hit;
      res.column    = COLUMN_W'(c);
      res.frame_end = px.flush && last;
      awaited_contours.push_back(res);
    end
    row_two_above_m[c] = row_above_m[c];
    row_above_m[c]     = cur;
    if (last) begin
      col_m = 0;
      if (px.flush) rows_m = 0;
      else if (rows_m < 2) rows_m++;
    end else begin
      col_m = c + 1;
    end
  endfunction

  task automatic flag_mismatch(string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Input driver: an offered item stays on the bus until it is taken.
  always @(negedge clk) begin
    if (!pix_busy) begin
      if (rst_n && pending_pixels.size() != 0 &&
          (steady_window() || $urandom_range(0, 99) >= 12)) begin
        pix_bus.valid <= 1'b1;
        pix_bus.red   <= pending_pixels[0].red;
        pix_bus.green <= pending_pixels[0].green;
        pix_bus.blue  <= pending_pixels[0].blue;
        pix_bus.flush <= pending_pixels[0].flush;
        pix_busy = 1'b1;
      end else begin
        pix_bus.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && pix_bus.valid && pix_bus.ready) begin
      mark_pixel(pending_pixels.pop_front());
      pix_busy = 1'b0;
      pixels_taken++;
    end
  end

  always @(negedge clk) begin
    res_bus.ready <= steady_window() || ($urandom_range(0, 99) >= 12);
  end

  always @(posedge clk) begin
    contour_t want;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      if (awaited_contours.size() == 0) begin
        flag_mismatch($sformatf("result at column %0d with none expected", res_bus.column));
      end else begin
        want = awaited_contours.pop_front();
        if (res_bus.edge_res !== want.edge_res)
          flag_mismatch($sformatf("column %0d edge_res %b, expected %b",
                                  want.column, res_bus.edge_res, want.edge_res));
        if (res_bus.column !== want.column)
          flag_mismatch($sformatf("column %0d, expected %0d", res_bus.column, want.column));
        if (res_bus.frame_end !== want.frame_end)
          flag_mismatch($sformatf("column %0d frame_end %b, expected %b",
                                  want.column, res_bus.frame_end, want.frame_end));
      end
    end
  end

  function automatic pixel_t random_pixel();
    pixel_t px;
    px.red   = $urandom_range(0, 255);
    px.green = $urandom_range(0, 255);
    px.blue  = $urandom_range(0, 255);
    case ($urandom_range(0, 7))
      0: begin
        px.red = 8'h00; px.green = 8'h00; px.blue = 8'h00;
      end
      1: begin
        px.red = 8'hFF; px.green = 8'hFF; px.blue = 8'hFF;
      end
      default: ;
    endcase
    px.flush = 1'b0;
    return px;
  endfunction

  function automatic void push_rgb(int unsigned r, int unsigned g, int unsigned b);
    pixel_t px;
    px.red   = CH_W'(r);
    px.green = CH_W'(g);
    px.blue  = CH_W'(b);
    px.flush = 1'b0;
    pending_pixels.push_back(px);
  endfunction

  function automatic void push_random();
    pending_pixels.push_back(random_pixel());
  endfunction

  function automatic void push_flush(int unsigned n);
    pixel_t px;
    repeat (n) begin
      px       = random_pixel();
      px.flush = 1'b1;
      pending_pixels.push_back(px);
    end
  endfunction

  // Waits until every item is taken and every result is in, then lets the
  // pipeline settle so that a register write finds the block idle.
  task automatic drain();
    while (pending_pixels.size() != 0 || awaited_contours.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int unsigned value);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    if (idx == REG_SUM_THRESHOLD) thr_m = THRESH_W'(value);
    else wid_m = IWIDTH_W'(value);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // One frame of w-pixel rows closed by a flush row. Noise is kept to rows
  // after the first so that the frame always ends on a row boundary.
  task automatic push_frame(int unsigned w, int unsigned rows, bit noisy);
    pixel_t px;
    bit     cut;
    cut = 1'b0;
    if (noisy && $urandom_range(0, 4) == 0) push_flush($urandom_range(1, 2));
    for (int unsigned r = 0; r < rows; r++) begin
      for (int unsigned c = 0; c < w; c++) begin
        px = random_pixel();
        if (noisy && r > 0) begin
          if (c + 1 < w && $urandom_range(0, 19) == 0) px.flush = 1'b1;
          if (c + 1 == w && r + 1 == rows && $urandom_range(0, 3) == 0) begin
            px.flush = 1'b1;
            cut      = 1'b1;
          end
        end
        pending_pixels.push_back(px);
      end
      if (noisy && $urandom_range(0, 29) == 0) drain();
    end
    push_flush(w);
    fed += rows * w + (cut ? 0 : w);
  endtask

  initial begin
    int unsigned thr;
    int unsigned wv;
    int unsigned w;
    rst_n         = 1'b0;
    pix_bus.valid = 1'b0;
    pix_bus.red   = '0;
    pix_bus.green = '0;
    pix_bus.blue  = '0;
    pix_bus.flush = 1'b0;
    res_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = REG_SUM_THRESHOLD;
    cfg_bus.data  = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: a stray flush before any row, then one full-width row.
    push_flush(1);
    push_frame(WIDTH_RESET, 1, 1'b0);
    drain();

    // Sums at both ends and on either side of the reset threshold, plus a
    // flush item inside a row.
    write_reg(REG_IMAGE_WIDTH, 4);
    push_rgb(0, 0, 0);
    push_rgb(255, 255, 255);
    push_rgb(100, 100, 100);
    push_rgb(100, 100, 99);
    push_rgb(255, 255, 255);
    push_flush(1);
    push_rgb(0, 0, 0);
    push_rgb(255, 0, 45);
    push_flush(4);
    drain();

    // The width shrinks in the middle of a row, with the input held off until
    // all results are in.
    write_reg(REG_IMAGE_WIDTH, 5);
    repeat (8) push_random();
    drain();
    write_reg(REG_IMAGE_WIDTH, 2);
    repeat (3) push_random();
    push_flush(2);
    drain();

    // A width beyond the store acts as the store depth, so the first row
    // must not end early. The row is then cut short and the frame closed.
    write_reg(REG_SUM_THRESHOLD, 382);
    write_reg(REG_IMAGE_WIDTH, MAX_WIDTH + 1);
    repeat (6) push_random();
    drain();
    write_reg(REG_IMAGE_WIDTH, 4);
    push_random();
    push_flush(4);
    drain();

    fed = 0;
    while (fed < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       thr = 0;
        1:       thr = 765;
        2:       thr = $urandom_range(766, 1023);
        3:       thr = $urandom_range(0, 2047);
        default: thr = $urandom_range(150, 600);
      endcase
      case ($urandom_range(0, 9))
        0:       wv = 0;
        1:       wv = 1;
        2:       wv = 2;
        3:       wv = $urandom_range(13, 48);
        default: wv = $urandom_range(3, 12);
      endcase
      write_reg(REG_SUM_THRESHOLD, thr);
      write_reg(REG_IMAGE_WIDTH, wv);
      w = (wv == 0) ? 1 : wv;
      repeat ($urandom_range(1, 3))
        push_frame(w, (w > 12) ? $urandom_range(1, 3) : $urandom_range(1, 6), 1'b1);
      drain();
    end

    drain();
    if (mismatches == 0) begin
      $display("threshold_outer_boundary_marker regression: pass");
    end else begin
      $display("threshold_outer_boundary_marker regression: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("threshold_outer_boundary_marker regression: fail");
    $finish;
  end

endmodule
`default_nettype wire

>>> threshold_outer_boundary_marker.f
design/tobm_pkg.sv
design/tobm_pix_if.sv
design/tobm_res_if.sv
design/tobm_cfg_if.sv
design/tobm_ram.sv
design/tobm_cfg_regs.sv
design/tobm_window.sv
design/threshold_outer_boundary_marker.sv
sim/tb_threshold_outer_boundary_marker.sv
